// ===== src/bsfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsfr_pkg;

	localparam logic [7:0]  FLAG_BYTE = 8'h7E;
	localparam logic [7:0]  ESC_BYTE  = 8'h7D;
	localparam logic [7:0]  ESC_LOW   = 8'h5D;
	localparam logic [7:0]  ESC_HIGH  = 8'h5E;
	localparam logic [7:0]  ESC_XOR   = 8'h20;
	localparam logic [12:0] COUNT_MAX = 13'h1FFF;
	localparam logic [11:0] MAX_FRAME_RESET = 12'd256;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_START  = 2'd1,
		MODE_ESCAPE = 2'd2,
		MODE_RECV   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_END     = 2'd1,
		KIND_ESC_ERR = 2'd2,
		KIND_OVF_ERR = 2'd3
	} kind_t;

	typedef struct packed {
		mode_t       mode;
		logic [12:0] count;
	} rx_state_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  data;
		logic [12:0] pos;
	} rx_result_t;

endpackage

`default_nettype wire

// ===== src/bsfr_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsfr_decode
	import bsfr_pkg::*;
(
	input  wire rx_state_t  cur,
	input  wire logic [7:0]  line_byte,
	input  wire logic [11:0] max_frame_bytes,
	output rx_state_t        nxt,
	output rx_result_t       res
);

	logic [12:0] base;
	logic        store;
	logic [7:0]  store_data;

	always_comb begin
		nxt        = cur;
		res        = '0;
		res.kind   = KIND_DATA;
		store      = 1'b0;
		store_data = line_byte;
		base       = cur.count;
		case (cur.mode)
			MODE_IDLE: begin
				if (line_byte == FLAG_BYTE) begin
					nxt.count = '0;
					nxt.mode  = MODE_START;
				end
			end
			MODE_START: begin
				if (line_byte == ESC_BYTE) begin
					nxt.count = '0;
					nxt.mode  = MODE_ESCAPE;
				end else if (line_byte != FLAG_BYTE) begin
					base  = '0;
					store = 1'b1;
				end
			end
			MODE_ESCAPE: begin
				if (line_byte inside {ESC_LOW, ESC_HIGH}) begin
					store      = 1'b1;
					store_data = line_byte ^ ESC_XOR;
				end else begin
					nxt.count = '0;
					nxt.mode  = MODE_IDLE;
					res.valid = 1'b1;
					res.kind  = KIND_ESC_ERR;
				end
			end
			MODE_RECV: begin
				if (cur.count > {1'b0, max_frame_bytes}) begin
					nxt.count = '0;
					nxt.mode  = MODE_IDLE;
					res.valid = 1'b1;
					res.kind  = KIND_OVF_ERR;
				end else if (line_byte == ESC_BYTE) begin
					nxt.mode = MODE_ESCAPE;
				end else if (line_byte == FLAG_BYTE) begin
					nxt.mode  = MODE_START;
					res.valid = 1'b1;
					res.kind  = KIND_END;
					res.pos   = cur.count;
				end else begin
					store = 1'b1;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
		if (store) begin
			nxt.mode  = MODE_RECV;
			nxt.count = (base != COUNT_MAX) ? base + 13'd1 : base;
			res.valid = 1'b1;
			res.kind  = KIND_DATA;
			res.data  = store_data;
			res.pos   = base;
		end
	end

endmodule

`default_nettype wire

// ===== src/bsfr_out_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bsfr_out_reg
	import bsfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire rx_result_t  res,
	input  wire logic        out_stall,
	output logic             free,
	output logic             out_valid,
	output logic [1:0]       result_kind,
	output logic [7:0]       data_byte,
	output logic [12:0]      byte_position
);

	logic       valid_q;
	kind_t      kind_q;
	logic [7:0] data_q;
	logic [12:0] pos_q;

	assign free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load && res.valid) begin
			kind_q <= res.kind;
			data_q <= res.data;
			pos_q  <= res.pos;
		end
	end

	assign out_valid     = valid_q;
	assign result_kind   = kind_q;
	assign data_byte     = data_q;
	assign byte_position = pos_q;

endmodule

`default_nettype wire

// ===== src/byte_stuffed_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// byte-stuffed frame receiver
// input channel: line_byte with in_valid / in_stall, one raw line byte per item
// output channel: result_kind, data_byte, byte_position with out_valid / out_stall
// config: cfg_wr_en with cfg_wr_data writes max_frame_bytes; write only when idle
// each accepted byte yields zero or one result item (data, frame end, escape
// error, overflow error)
// an accepted byte is held in the input register and decoded from there; its result
// is loaded into the output register once that register is free
// throughput: one byte per cycle while in_stall is low, set by the mode/count update
// between the input register and the output register
// reset: mode idle, count zero, max_frame_bytes 256, both registers empty
// stall: a held result stays on the output unchanged; an empty input register still
// takes one more byte, then in_stall rises until the output is taken
module byte_stuffed_frame_receiver
	import bsfr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [11:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  line_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       result_kind,
	output logic [7:0]       data_byte,
	output logic [12:0]      byte_position
);

	logic [11:0] max_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	rx_state_t   state_q;
	rx_state_t   state_nxt;
	rx_result_t  res;
	logic        free;
	logic        advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_FRAME_RESET;
		end else if (cfg_wr_en) begin
			max_q <= cfg_wr_data;
		end
	end

	assign advance  = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= line_byte;
		end
	end

	bsfr_decode u_decode (
		.cur             (state_q),
		.line_byte       (byte_s1),
		.max_frame_bytes (max_q),
		.nxt             (state_nxt),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode  <= MODE_IDLE;
			state_q.count <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	bsfr_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance),
		.res           (res),
		.out_stall     (out_stall),
		.free          (free),
		.out_valid     (out_valid),
		.result_kind   (result_kind),
		.data_byte     (data_byte),
		.byte_position (byte_position)
	);

	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_IDLE |-> state_q.count == 13'd0)
		else $error("count not zero in idle mode");

	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_ESC_ERR || result_kind == KIND_OVF_ERR)
		|-> data_byte == 8'd0 && byte_position == 13'd0)
		else $error("error result carries nonzero fields");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item not held in input register");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
	import bsfr_pkg::*;
();

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [12:0] pos;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [11:0] cfg_wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  line_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  result_kind;
	logic [7:0]  data_byte;
	logic [12:0] byte_position;

	logic [7:0]    pending_bytes[$];
	frame_result_t expected_results[$];
	mode_t         model_mode = MODE_IDLE;
	logic [12:0]   model_count = '0;
	logic [11:0]   model_max = MAX_FRAME_RESET;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	int            error_count = 0;
	int            bytes_queued = 0;
	int            bytes_accepted = 0;

	byte_stuffed_frame_receiver dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line_byte    (line_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.data_byte    (data_byte),
		.byte_position(byte_position)
	);

	always #1 clk = ~clk;

	task automatic decode_line_byte(input logic [7:0] b);
		frame_result_t r;
		logic          hit;
		logic          store;
		logic [7:0]    value;
		r = '0;
		hit = 1'b0;
		store = 1'b0;
		value = '0;
		case (model_mode)
			MODE_IDLE: begin
				if (b == FLAG_BYTE) begin
					model_count = '0;
					model_mode = MODE_START;
				end
			end
			MODE_START: begin
				if (b == ESC_BYTE) begin
					model_count = '0;
					model_mode = MODE_ESCAPE;
				end else if (b != FLAG_BYTE) begin
					model_count = '0;
					store = 1'b1;
					value = b;
				end
			end
			MODE_ESCAPE: begin
				if (b == ESC_LOW || b == ESC_HIGH) begin
					store = 1'b1;
					value = b ^ ESC_XOR;
				end else begin
					model_count = '0;
					model_mode = MODE_IDLE;
					hit = 1'b1;
					r.kind = KIND_ESC_ERR;
				end
			end
			default: begin
				if (model_count > {1'b0, model_max}) begin
					model_count = '0;
					model_mode = MODE_IDLE;
					hit = 1'b1;
					r.kind = KIND_OVF_ERR;
				end else if (b == ESC_BYTE) begin
					model_mode = MODE_ESCAPE;
				end else if (b == FLAG_BYTE) begin
					model_mode = MODE_START;
					hit = 1'b1;
					r.kind = KIND_END;
					r.pos = model_count;
				end else begin
					store = 1'b1;
					value = b;
				end
			end
		endcase
		if (store) begin
			hit = 1'b1;
			r.kind = KIND_DATA;
			r.data = value;
			r.pos = model_count;
			if (model_count != COUNT_MAX)
				model_count = model_count + 13'd1;
			model_mode = MODE_RECV;
		end
		if (hit)
			expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			line_byte <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_line_byte(line_byte);
				bytes_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					line_byte <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin : check_result
			frame_result_t want;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: expected no item, actual kind %0d data %h pos %0d",
						$time, result_kind, data_byte, byte_position);
				end else begin
					want = expected_results.pop_front();
					if (result_kind !== want.kind) begin
						error_count++;
						$display("%0t: result_kind expected %0d actual %0d", $time,
							want.kind, result_kind);
					end
					if (data_byte !== want.data) begin
						error_count++;
						$display("%0t: data_byte expected %h actual %h", $time,
							want.data, data_byte);
					end
					if (byte_position !== want.pos) begin
						error_count++;
						$display("%0t: byte_position expected %0d actual %0d", $time,
							want.pos, byte_position);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	function automatic logic [7:0] rand_line_byte();
		case ($urandom_range(9))
			0: return FLAG_BYTE;
			1: return ESC_BYTE;
			2: return ESC_LOW;
			3: return ESC_HIGH;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// opening flag, stuffed content with some broken escapes, usually a closing flag
	task automatic push_frame(input int len, input int broken_pct);
		logic [7:0] v;
		push_byte(FLAG_BYTE);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < broken_pct) begin
				push_byte(ESC_BYTE);
				push_byte(rand_line_byte());
			end else begin
				v = rand_line_byte();
				if (v == FLAG_BYTE || v == ESC_BYTE) begin
					push_byte(ESC_BYTE);
					push_byte(v ^ ESC_XOR);
				end else begin
					push_byte(v);
				end
			end
		end
		if ($urandom_range(4) != 0)
			push_byte(FLAG_BYTE);
	endtask

	task automatic push_random(input int n);
		int target;
		int len;
		target = bytes_queued + n;
		while (bytes_queued < target) begin
			if ($urandom_range(99) < 10) begin
				repeat ($urandom_range(1, 4)) push_byte(rand_line_byte());
			end else begin
				len = $urandom_range(0, 8);
				if (model_max < 40 && $urandom_range(2) == 0)
					len = $urandom_range(model_max, model_max + 2);
				push_frame(len, 10);
			end
		end
	endtask

	task automatic write_max(input logic [11:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		model_max = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic drain();
		while (bytes_accepted != bytes_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_idling(input int send_pct, input int stall_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default maximum: escapes, frame ends, escape errors, flag runs
		push_byte(8'h7E); push_byte(8'h00); push_byte(8'hFF);
		push_byte(8'h7D); push_byte(8'h5D); push_byte(8'h7D); push_byte(8'h5E);
		push_byte(8'h7E);
		push_byte(8'h7D); push_byte(8'h5E); push_byte(8'h41); push_byte(8'h7E);
		push_byte(8'h7D); push_byte(8'h33);
		push_byte(8'h55); push_byte(8'h7E); push_byte(8'h7E); push_byte(8'h12);
		push_byte(8'h7D); push_byte(8'h7E);
		push_byte(8'h7E); push_byte(8'h7D); push_byte(8'h7D); push_byte(8'h7E);
		drain();

		// overflow at a maximum of one
		write_max(12'd1);
		push_byte(8'h7E); push_byte(8'h11); push_byte(8'h22); push_byte(8'h33);
		push_byte(8'h7E); push_byte(8'h44); push_byte(8'h7E);
		drain();

		// zero maximum
		write_max(12'd0);
		push_byte(8'h7E); push_byte(8'h55); push_byte(8'h66);
		push_byte(8'h7E); push_byte(8'h7E); push_byte(8'h77); push_byte(8'h7E);
		drain();

		// largest maximum
		write_max(12'd4095);
		push_frame(20, 0);
		drain();

		write_max(12'd12);
		set_idling(0, 0);
		push_random(100);
		drain();

		write_max(12'd1);
		set_idling(59, 0);
		push_random(100);
		drain();

		write_max(12'($urandom_range(2, 40)));
		set_idling(0, 59);
		push_random(100);
		drain();

		write_max(12'd4095);
		set_idling(9, 9);
		push_random(50);
		drain();
		push_random(50);
		drain();

		write_max(12'($urandom_range(1, 4095)));
		set_idling(0, 0);
		push_random(100);
		drain();

		write_max(12'd3);
		set_idling(9, 9);
		push_random(100);
		drain();

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/bsfr_pkg.sv
src/bsfr_decode.sv
src/bsfr_out_reg.sv
src/byte_stuffed_frame_receiver.sv
tb/sv/tb_top.sv
